// ----- src/ukvt_pkg.sv -----
package ukvt_pkg;

   // Table size and the widths that follow from it.
   localparam int CAPACITY    = 64;
   localparam int IDX_W       = $clog2(CAPACITY);
   localparam int CNT_W       = $clog2(CAPACITY + 1);
   localparam int DATA_W      = 32;
   localparam int ENTRY_CNT_W = 7;

   // Command codes of a request.
   typedef enum logic [2:0] {
      CMD_ACCESS = 3'd0,
      CMD_WRITE  = 3'd1,
      CMD_PEEK   = 3'd2,
      CMD_DELETE = 3'd3,
      CMD_CLEAR  = 3'd4
   } cmd_type;

   // Status codes of a response.
   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_MISSING = 2'd1,
      ST_FULL    = 2'd2
   } status_type;

   // Update controls broadcast from the sequencer to every cell.
   typedef struct packed {
      logic                delete_en;
      logic                update_en;
      logic                append_en;
      logic [IDX_W-1:0]    hit_pos;
      logic [CNT_W-1:0]    count;
      logic [DATA_W-1:0]   app_key;
      logic [DATA_W-1:0]   app_value;
   } ctl_type;

endpackage

// ----- src/ukvt_cell.sv -----
module ukvt_cell
   import ukvt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [IDX_W-1:0]    cell_idx,
   input  logic                lookup_en,
   input  logic [DATA_W-1:0]   lookup_key,
   input  ctl_type             ctl,
   input  logic [DATA_W-1:0]   next_key,
   input  logic [DATA_W-1:0]   next_value,
   output logic [DATA_W-1:0]   key_out,
   output logic [DATA_W-1:0]   value_out,
   output logic [DATA_W-1:0]   hit_value,
   output logic                match
);

   logic [DATA_W-1:0] key_ff;
   logic [DATA_W-1:0] key_in;
   logic [DATA_W-1:0] value_ff;
   logic [DATA_W-1:0] value_in;
   logic              match_ff;
   logic              match_in;
   logic              occupied;

   // The cell holds a live entry when its place lies below the fill count.
   assign occupied = CNT_W'(cell_idx) < ctl.count;

   // Compare the incoming key while the request is being accepted.
   assign match_in = lookup_en && occupied && (key_ff == lookup_key);

   // Shift down on delete, overwrite on a write hit, or take a new entry at the tail.
   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      if (ctl.delete_en && (cell_idx >= ctl.hit_pos)) begin
         key_in   = next_key;
         value_in = next_value;
      end else if (ctl.update_en && match_ff) begin
         value_in = ctl.app_value;
      end else if (ctl.append_en && (CNT_W'(cell_idx) == ctl.count)) begin
         key_in   = ctl.app_key;
         value_in = ctl.app_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

   assign key_out   = key_ff;
   assign value_out = value_ff;
   assign hit_value = match_ff ? value_ff : '0;
   assign match     = match_ff;

endmodule

// ----- src/unsorted_key_value_table.sv -----
// Channel   | Ports                                              | Handshake
// ----------+----------------------------------------------------+---------------------------
// request   | req_cmd, req_key, req_new_value                    | start high while busy low
// response  | rsp_value, rsp_found, rsp_status, rsp_entry_count  | rsp_valid, one cycle
//
// Every cell compares its key at the accepting edge, and the hit, append or
// compacting shift is applied in the following cycle, the update state.
// The response strobe is registered as the update state ends, and a new request may
// be accepted in that same cycle; no request is taken while busy is high.
// Synchronous reset empties the table; the cell contents are not cleared.
// The receiver cannot stall; each response is shown for exactly one cycle.
module unsorted_key_value_table
   import ukvt_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [2:0]                    req_cmd,
   input  logic signed [DATA_W-1:0]      req_key,
   input  logic signed [DATA_W-1:0]      req_new_value,
   output logic                          rsp_valid,
   output logic signed [DATA_W-1:0]      rsp_value,
   output logic                          rsp_found,
   output logic [1:0]                    rsp_status,
   output logic [ENTRY_CNT_W-1:0]        rsp_entry_count
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type                    state_ff;
   state_type                    state_in;
   cmd_type                      cmd_ff;
   logic [DATA_W-1:0]            key_ff;
   logic [DATA_W-1:0]            nv_ff;
   logic [CNT_W-1:0]             count_ff;
   logic [CNT_W-1:0]             count_in;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic [DATA_W-1:0]            rsp_value_ff;
   logic [DATA_W-1:0]            rsp_value_in;
   logic                         rsp_found_ff;
   logic                         rsp_found_in;
   status_type                   rsp_status_ff;
   status_type                   rsp_status_in;
   logic [ENTRY_CNT_W-1:0]       rsp_count_ff;
   logic [ENTRY_CNT_W-1:0]       rsp_count_in;

   logic                         accept;
   logic                         exec;
   logic                         hit;
   logic                         full;
   logic [IDX_W-1:0]             hit_pos;
   logic [DATA_W-1:0]            hit_value;
   ctl_type                      ctl;
   logic [CAPACITY-1:0]          match_vec;
   logic [DATA_W-1:0]            key_vec   [CAPACITY];
   logic [DATA_W-1:0]            value_vec [CAPACITY];
   logic [DATA_W-1:0]            hval_vec  [CAPACITY];
   logic [DATA_W-1:0]            next_key_vec   [CAPACITY];
   logic [DATA_W-1:0]            next_value_vec [CAPACITY];

   assign exec   = (state_ff == S_EXEC);
   assign busy   = exec;
   assign accept = start && !busy;

   // Row of cells; each one hands its entry to the cell below it.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == CAPACITY - 1) begin : g_tail
         assign next_key_vec[i]   = '0;
         assign next_value_vec[i] = '0;
      end else begin : g_body
         assign next_key_vec[i]   = key_vec[i + 1];
         assign next_value_vec[i] = value_vec[i + 1];
      end

      ukvt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_idx   (IDX_W'(i)),
         .lookup_en  (accept),
         .lookup_key (req_key),
         .ctl        (ctl),
         .next_key   (next_key_vec[i]),
         .next_value (next_value_vec[i]),
         .key_out    (key_vec[i]),
         .value_out  (value_vec[i]),
         .hit_value  (hval_vec[i]),
         .match      (match_vec[i])
      );
   end

   // Keys are unique, so at most one cell matches: encode its place and value by OR.
   always_comb begin
      hit_pos   = '0;
      hit_value = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (match_vec[i]) begin
            hit_pos = hit_pos | IDX_W'(i);
         end
         hit_value = hit_value | hval_vec[i];
      end
   end

   assign hit  = |match_vec;
   assign full = (count_ff == CNT_W'(CAPACITY));

   // Decide the table update and the response for the request in hand.
   always_comb begin
      ctl.delete_en = 1'b0;
      ctl.update_en = 1'b0;
      ctl.append_en = 1'b0;
      ctl.hit_pos   = hit_pos;
      ctl.count     = count_ff;
      ctl.app_key   = key_ff;
      ctl.app_value = (cmd_ff == CMD_WRITE) ? nv_ff : '0;
      count_in      = count_ff;
      rsp_value_in  = '0;
      rsp_found_in  = 1'b0;
      rsp_status_in = ST_OK;
      case (cmd_ff)
         CMD_ACCESS, CMD_WRITE: begin
            rsp_found_in = hit;
            if (hit) begin
               ctl.update_en = exec && (cmd_ff == CMD_WRITE);
               rsp_value_in  = (cmd_ff == CMD_WRITE) ? nv_ff : hit_value;
            end else if (full) begin
               rsp_status_in = ST_FULL;
            end else begin
               ctl.append_en = exec;
               rsp_value_in  = ctl.app_value;
               count_in      = count_ff + CNT_W'(1);
            end
         end
         CMD_PEEK: begin
            rsp_found_in = hit;
            rsp_value_in = hit_value;
         end
         CMD_DELETE: begin
            rsp_found_in = hit;
            if (hit) begin
               ctl.delete_en = exec;
               count_in      = count_ff - CNT_W'(1);
            end else begin
               rsp_status_in = ST_MISSING;
            end
         end
         CMD_CLEAR: begin
            count_in = '0;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
      rsp_count_in = ENTRY_CNT_W'(count_in);
   end

   // Sequencer: idle until a request is accepted, then the update state before returning to idle.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (exec) begin
            count_ff <= count_in;
         end
      end
   end

   // Request capture and response registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= cmd_type'(req_cmd);
         key_ff <= req_key;
         nv_ff  <= req_new_value;
      end
      if (exec) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_found_ff  <= rsp_found_in;
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= rsp_count_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_value       = rsp_value_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule
